### design/mwm_pkg.sv
// Package for the mecanum wheel mixer: field widths, fixed constants,
// register indexes and the enum types of the sequencer. No dependencies.
package mwm_pkg;

    localparam int AXIS_W    = 16;   // Q1.15 stick axes and wheel commands
    localparam int CFG_W     = 16;   // widest configuration register
    localparam int CFG_IDX_W = 2;
    localparam int DIR_W     = 9;    // hat angle in degrees
    localparam int MAG_W     = 17;   // magnitudes up to three full-scale axes
    localparam int SUM_W     = 18;   // signed wheel sums
    localparam int PROD_W    = 34;   // |sum| * throttle
    localparam int DIVN_W    = 36;   // 2 * product + scale
    localparam int QUO_W     = 15;   // quotient bits below the saturation point
    localparam int MUL_STEPS = 17;   // one multiplier bit per cycle
    localparam int STEP_W    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_THR_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_RANGE = 2'd1;

    localparam logic [CFG_W-1:0] THR_MIN_RESET   = 16'd4260;
    localparam logic [CFG_W-1:0] THR_RANGE_RESET = 16'd28508;

    localparam logic [DIR_W-1:0] DIR_0   = 9'd0;
    localparam logic [DIR_W-1:0] DIR_90  = 9'd90;
    localparam logic [DIR_W-1:0] DIR_180 = 9'd180;
    localparam logic [DIR_W-1:0] DIR_270 = 9'd270;

    localparam logic [MAG_W-1:0]  FULL_SCALE = 17'd32768;
    localparam logic [AXIS_W-1:0] CMD_MAX    = 16'd32767;
    localparam logic [AXIS_W-1:0] CMD_MIN_CODE = 16'h8000;

    localparam logic [1:0] WHEEL_FR = 2'd0;
    localparam logic [1:0] WHEEL_FL = 2'd1;
    localparam logic [1:0] WHEEL_BR = 2'd2;
    localparam logic [1:0] WHEEL_BL = 2'd3;

    typedef enum logic [1:0] {
        ROT_0,
        ROT_90,
        ROT_180,
        ROT_270
    } rot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LOAD,
        ST_MUL,
        ST_THR,
        ST_DIV_LOAD,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } state_t;

endpackage

### design/mecanum_wheel_mixer_top.sv
// Mecanum wheel mixer: one joystick sample in, four wheel commands out.
// Depends on mwm_pkg; holds a bit-serial multiplier and a bit-serial divider.
//
//   channel   signals                                      direction
//   input     in_valid/in_ready, four axes, hat fields     into block
//   result    out_valid/out_ready, four wheel commands     out of block
//   config    cfg_write_en, cfg_index, cfg_data            into block, no wait
//
// A sample whose direction is 0, 90, 180 or 270 degrees passes, in order, through its
// acceptance, the throttle product, per wheel a multiply, a divide, set-up and store,
// and a hand-over, as both serial units retire one bit per cycle; no new sample is
// taken before the hand-over is done. Any other direction gives no result and
// in_ready stays high. A stalled output stops the sequencer only at its hand-over.
// Reset is asynchronous and leaves the block idle with direction 0, default throttle.
module mecanum_wheel_mixer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mwm_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [mwm_pkg::AXIS_W-1:0] strafe_axis,
    input  logic signed [mwm_pkg::AXIS_W-1:0] forward_axis,
    input  logic signed [mwm_pkg::AXIS_W-1:0] turn_axis,
    input  logic signed [mwm_pkg::AXIS_W-1:0] throttle_axis,
    input  logic                             hat_valid,
    input  logic [mwm_pkg::DIR_W-1:0]        hat_angle,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [mwm_pkg::AXIS_W-1:0] front_right,
    output logic signed [mwm_pkg::AXIS_W-1:0] front_left,
    output logic signed [mwm_pkg::AXIS_W-1:0] back_right,
    output logic signed [mwm_pkg::AXIS_W-1:0] back_left
);
    import mwm_pkg::*;

    function automatic logic [MAG_W-1:0] abs17(input logic signed [AXIS_W-1:0] v);
        logic [MAG_W-1:0] e;
        logic [MAG_W-1:0] n;
        e = {v[AXIS_W-1], v};
        n = -e;
        abs17 = v[AXIS_W-1] ? n : e;
    endfunction

    // Control state
    state_t               state_reg, state_next;
    logic                 thr_phase_reg, thr_phase_next;
    logic [1:0]           wheel_reg, wheel_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DIR_W-1:0]     dir_reg, dir_next;
    logic [CFG_W-1:0]     thr_min_reg, thr_min_next;
    logic [CFG_W-1:0]     thr_range_reg, thr_range_next;

    // Datapath
    logic signed [AXIS_W-1:0] x_reg, y_reg, t_reg, a_reg;
    rot_t                 rot_reg;
    logic [MAG_W-1:0]     mcand_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [MAG_W-1:0]     thr_reg;
    logic [MAG_W-1:0]     scl_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     dq_reg;
    logic                 ovf_reg;
    logic [AXIS_W-1:0]    res_reg [4];
    logic [AXIS_W-1:0]    fr_reg, fl_reg, br_reg, bl_reg;

    // Sequencer strobes
    logic in_accept;
    logic do_mul_load, do_mul, do_thr, do_div_load, do_div, do_store, do_move;

    // Direction decode at acceptance
    logic [DIR_W-1:0] dir_new;
    logic             dir_match;
    rot_t             rot_new;

    always_comb
    begin
        dir_new   = hat_valid ? hat_angle : dir_reg;
        dir_match = 1'b1;
        rot_new   = ROT_0;
        unique case (dir_new)
            DIR_0:   rot_new = ROT_0;
            DIR_90:  rot_new = ROT_90;
            DIR_180: rot_new = ROT_180;
            DIR_270: rot_new = ROT_270;
            default: dir_match = 1'b0;
        endcase
    end

    // Rotated frame and the sum for the wheel in hand
    logic signed [MAG_W-1:0] x17, y17, rx, ry;
    logic [SUM_W-1:0]        rx18, ry18, t18, sum_cur, sum_neg;
    logic                    x_pos, t_pos, left_wheel;
    logic [MAG_W-1:0]        sum_mag;

    always_comb
    begin
        x17 = {x_reg[AXIS_W-1], x_reg};
        y17 = {y_reg[AXIS_W-1], y_reg};
        unique case (rot_reg)
            ROT_0:
            begin
                rx = x17;
                ry = y17;
            end
            ROT_90:
            begin
                rx = -y17;
                ry = x17;
            end
            ROT_180:
            begin
                rx = -x17;
                ry = -y17;
            end
            ROT_270:
            begin
                rx = y17;
                ry = -x17;
            end
        endcase
        rx18 = {rx[MAG_W-1], rx};
        ry18 = {ry[MAG_W-1], ry};
        t18  = {{(SUM_W-AXIS_W){t_reg[AXIS_W-1]}}, t_reg};
        x_pos      = (wheel_reg == WHEEL_FR) || (wheel_reg == WHEEL_BL);
        t_pos      = (wheel_reg == WHEEL_FR) || (wheel_reg == WHEEL_BR);
        left_wheel = (wheel_reg == WHEEL_FL) || (wheel_reg == WHEEL_BL);
        sum_cur = ry18 + (x_pos ? rx18 : -rx18) + (t_pos ? t18 : -t18);
        sum_neg = -sum_cur;
        sum_mag = sum_cur[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_cur[MAG_W-1:0];
    end

    // Normalising scale and throttle multiplicand
    logic [MAG_W-1:0] scl_sum, scl_new, thr_mcand;
    logic [MAG_W-1:0] thr_new;

    always_comb
    begin
        scl_sum   = abs17(x_reg) + abs17(y_reg) + abs17(t_reg);
        scl_new   = (scl_sum < FULL_SCALE) ? FULL_SCALE : scl_sum;
        thr_mcand = FULL_SCALE - {a_reg[AXIS_W-1], a_reg};
        thr_new   = {1'b0, prod_reg[31:16]} + {1'b0, thr_min_reg};
    end

    // Shift-and-add multiplier: one multiplier bit per cycle, LSB first.
    logic [SUM_W-1:0]  mul_sum;
    logic [PROD_W-1:0] prod_step;

    always_comb
    begin
        mul_sum   = {1'b0, prod_reg[PROD_W-1:MAG_W]}
                  + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_step = {mul_sum, prod_reg[MAG_W-1:1]};
    end

    // Restoring divider: rounding is folded in as (2m + s) / 2s; quotients from
    // 2^15 upwards saturate, so only fifteen quotient bits are developed.
    logic [DIVN_W-1:0] div_n;
    logic [SUM_W-1:0]  div_d;
    logic              div_ovf;
    logic [SUM_W:0]    div_try, div_diff;
    logic [SUM_W-1:0]  rem_step;
    logic              qbit;

    always_comb
    begin
        div_n    = {1'b0, prod_reg, 1'b0} + {{(DIVN_W-MAG_W){1'b0}}, scl_reg};
        div_d    = {scl_reg, 1'b0};
        div_ovf  = div_n[DIVN_W-1:QUO_W] >= {3'b000, div_d};
        div_try  = {rem_reg, dq_reg[QUO_W-1]};
        div_diff = div_try - {1'b0, div_d};
        qbit     = !div_diff[SUM_W];
        rem_step = qbit ? div_diff[SUM_W-1:0] : div_try[SUM_W-1:0];
    end

    // Signed, saturated command for the wheel in hand
    logic [AXIS_W-1:0] res_mag, res_val;

    always_comb
    begin
        res_mag = ovf_reg ? CMD_MAX : {1'b0, dq_reg};
        res_val = (sum_cur[SUM_W-1] ^ left_wheel) ? -res_mag : res_mag;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && dir_match)
                begin
                    state_next = ST_MUL_LOAD;
                end
            end
            ST_MUL_LOAD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    state_next = thr_phase_reg ? ST_THR : ST_DIV_LOAD;
                end
            end
            ST_THR:
            begin
                state_next = ST_MUL_LOAD;
            end
            ST_DIV_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                state_next = (wheel_reg == WHEEL_BL) ? ST_DONE : ST_MUL_LOAD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready    = 1'b0;
        do_mul_load = 1'b0;
        do_mul      = 1'b0;
        do_thr      = 1'b0;
        do_div_load = 1'b0;
        do_div      = 1'b0;
        do_store    = 1'b0;
        do_move     = 1'b0;
        unique case (state_reg)
            ST_IDLE:     in_ready    = 1'b1;
            ST_MUL_LOAD: do_mul_load = 1'b1;
            ST_MUL:      do_mul      = 1'b1;
            ST_THR:      do_thr      = 1'b1;
            ST_DIV_LOAD: do_div_load = 1'b1;
            ST_DIV:      do_div      = 1'b1;
            ST_STORE:    do_store    = 1'b1;
            ST_DONE:     do_move     = !out_valid_reg || out_ready;
        endcase
    end

    assign in_accept = in_valid && in_ready;

    // Control next values
    always_comb
    begin
        dir_next       = in_accept ? dir_new : dir_reg;
        thr_phase_next = in_accept ? 1'b1 : (do_thr ? 1'b0 : thr_phase_reg);
        wheel_next     = in_accept ? WHEEL_FR : (do_store ? wheel_reg + 2'd1 : wheel_reg);
        step_next      = (do_mul_load || do_div_load) ? '0
                       : ((do_mul || do_div) ? step_reg + STEP_W'(1) : step_reg);
        out_valid_next = do_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        thr_min_next   = thr_min_reg;
        thr_range_next = thr_range_reg;
        if (cfg_write_en && (cfg_index == CFG_THR_MIN))
        begin
            thr_min_next = cfg_data;
        end
        if (cfg_write_en && (cfg_index == CFG_THR_RANGE))
        begin
            thr_range_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_phase_reg <= 1'b0;
            wheel_reg     <= WHEEL_FR;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            dir_reg       <= DIR_0;
            thr_min_reg   <= THR_MIN_RESET;
            thr_range_reg <= THR_RANGE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            thr_phase_reg <= thr_phase_next;
            wheel_reg     <= wheel_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            dir_reg       <= dir_next;
            thr_min_reg   <= thr_min_next;
            thr_range_reg <= thr_range_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg   <= strafe_axis;
            y_reg   <= forward_axis;
            t_reg   <= turn_axis;
            a_reg   <= throttle_axis;
            rot_reg <= rot_new;
        end
        if (do_mul_load)
        begin
            if (thr_phase_reg)
            begin
                mcand_reg <= thr_mcand;
                prod_reg  <= {{(PROD_W-CFG_W){1'b0}}, thr_range_reg};
                scl_reg   <= scl_new;
            end
            else
            begin
                mcand_reg <= sum_mag;
                prod_reg  <= {{(PROD_W-MAG_W){1'b0}}, thr_reg};
            end
        end
        if (do_mul)
        begin
            prod_reg <= prod_step;
        end
        if (do_thr)
        begin
            thr_reg <= thr_new;
        end
        if (do_div_load)
        begin
            ovf_reg <= div_ovf;
            rem_reg <= div_n[QUO_W+SUM_W-1:QUO_W];
            dq_reg  <= div_n[QUO_W-1:0];
        end
        if (do_div)
        begin
            rem_reg <= rem_step;
            dq_reg  <= {dq_reg[QUO_W-2:0], qbit};
        end
        if (do_store)
        begin
            res_reg[wheel_reg] <= res_val;
        end
        if (do_move)
        begin
            fr_reg <= res_reg[WHEEL_FR];
            fl_reg <= res_reg[WHEEL_FL];
            br_reg <= res_reg[WHEEL_BR];
            bl_reg <= res_reg[WHEEL_BL];
        end
    end

    assign out_valid   = out_valid_reg;
    assign front_right = fr_reg;
    assign front_left  = fl_reg;
    assign back_right  = br_reg;
    assign back_left   = bl_reg;

    // The drive direction only moves when a transaction carries a pressed hat.
    a_dir_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready && hat_valid) |=> $stable(dir_reg))
        else $error("drive direction changed without a hat transaction");

    // Restoring division keeps its partial remainder below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && !ovf_reg |-> (rem_reg < {scl_reg, 1'b0}))
        else $error("divider remainder out of range");

    // A wheel division must never start before the throttle factor is formed.
    a_thr_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_LOAD) |-> !thr_phase_reg)
        else $error("division started during throttle phase");

    // Saturation keeps every command inside the symmetric range.
    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (fr_reg != CMD_MIN_CODE) && (fl_reg != CMD_MIN_CODE)
                       && (br_reg != CMD_MIN_CODE) && (bl_reg != CMD_MIN_CODE))
        else $error("wheel command outside saturation range");

endmodule

### tb/sv/mecanum_mix_checker.sv
// Scoreboard for the mecanum wheel mixer: follows the configuration port and both
// handshake channels, predicts every set of wheel commands and compares them.
// Depends on mwm_pkg only.
module mecanum_mix_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mwm_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic signed [mwm_pkg::AXIS_W-1:0]  strafe_axis,
    input  logic signed [mwm_pkg::AXIS_W-1:0]  forward_axis,
    input  logic signed [mwm_pkg::AXIS_W-1:0]  turn_axis,
    input  logic signed [mwm_pkg::AXIS_W-1:0]  throttle_axis,
    input  logic                               hat_valid,
    input  logic [mwm_pkg::DIR_W-1:0]          hat_angle,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [mwm_pkg::AXIS_W-1:0]  front_right,
    input  logic signed [mwm_pkg::AXIS_W-1:0]  front_left,
    input  logic signed [mwm_pkg::AXIS_W-1:0]  back_right,
    input  logic signed [mwm_pkg::AXIS_W-1:0]  back_left,
    output int                                 mismatches,
    output int                                 outstanding
);
    import mwm_pkg::*;

    // One set of wheel commands, indexed by the WHEEL_* constants.
    typedef logic [3:0][AXIS_W-1:0] wheel_set_t;

    string            wheel_name [4] = '{"front_right", "front_left", "back_right", "back_left"};
    logic [CFG_W-1:0] thr_min;
    logic [CFG_W-1:0] thr_span;
    logic [DIR_W-1:0] heading;
    wheel_set_t       expected_wheels [$];

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // total * throttle / scale, rounded half away from zero, clipped to CMD_MAX in magnitude.
    function automatic logic [AXIS_W-1:0] scaled_command(input longint total, thr, scl,
                                                         input bit negate);
        longint num;
        longint q;
        num = total * thr;
        q = (2 * magnitude(num) + scl) / (2 * scl);
        if (q > longint'(CMD_MAX))
            q = longint'(CMD_MAX);
        if ((num < 0) != negate)
            q = -q;
        return q[AXIS_W-1:0];
    endfunction

    function automatic bit mix_wheels(input logic [DIR_W-1:0] dir,
                                      input logic signed [AXIS_W-1:0] sx, sy, st, sa,
                                      output wheel_set_t w);
        longint x;
        longint y;
        longint t;
        longint a;
        longint rx;
        longint ry;
        longint scl;
        longint thr;
        x = sx;
        y = sy;
        t = st;
        a = sa;
        w = '0;
        case (dir)
            DIR_0:
            begin
                rx = x;
                ry = y;
            end
            DIR_90:
            begin
                rx = -y;
                ry = x;
            end
            DIR_180:
            begin
                rx = -x;
                ry = -y;
            end
            DIR_270:
            begin
                rx = y;
                ry = -x;
            end
            default:
                return 1'b0;
        endcase
        scl = magnitude(x) + magnitude(y) + magnitude(t);
        if (scl < longint'(FULL_SCALE))
            scl = longint'(FULL_SCALE);
        thr = (((longint'(FULL_SCALE) - a) * longint'(thr_span)) >>> 16) + longint'(thr_min);
        w[WHEEL_FR] = scaled_command(ry + rx + t, thr, scl, 1'b0);
        w[WHEEL_FL] = scaled_command(ry - rx - t, thr, scl, 1'b1);
        w[WHEEL_BR] = scaled_command(ry - rx + t, thr, scl, 1'b0);
        w[WHEEL_BL] = scaled_command(ry + rx - t, thr, scl, 1'b1);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        wheel_set_t got;
        wheel_set_t want;
        if (!rst_n)
        begin
            thr_min = THR_MIN_RESET;
            thr_span = THR_RANGE_RESET;
            heading = DIR_0;
            expected_wheels.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_THR_MIN:   thr_min = cfg_data;
                    CFG_THR_RANGE: thr_span = cfg_data;
                    default: ;
                endcase
            end

            // Results are retired before a new sample is queued, so a result can
            // never be matched against the transaction accepted at the same edge.
            if (out_valid && out_ready)
            begin
                got[WHEEL_FR] = front_right;
                got[WHEEL_FL] = front_left;
                got[WHEEL_BR] = back_right;
                got[WHEEL_BL] = back_left;
                if (expected_wheels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: wheel transaction expected none actual %0d %0d %0d %0d",
                             $time, front_right, front_left, back_right, back_left);
                end
                else
                begin
                    want = expected_wheels.pop_front();
                    for (int i = 0; i < 4; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            mismatches++;
                            $display("%0t: %s expected %0d actual %0d", $time,
                                     wheel_name[i], $signed(want[i]), $signed(got[i]));
                        end
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (hat_valid)
                    heading = hat_angle;
                if (mix_wheels(heading, strafe_axis, forward_axis, turn_axis, throttle_axis,
                               want))
                    expected_wheels.push_back(want);
            end

            outstanding = expected_wheels.size();
        end
    end

endmodule

### tb/sv/tb_mecanum_wheel_mixer_top.sv
// Testbench top for mecanum_wheel_mixer_top: drives directed and random joystick
// transactions under several throttle settings and idling patterns, and gives the
// verdict from the counts kept by mecanum_mix_checker. Depends on mwm_pkg.
module tb_mecanum_wheel_mixer_top;
    import mwm_pkg::*;

    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int SETTLE_CYCLES   = 200;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_ITEMS     = 350;

    // Indexes past the two registers; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [AXIS_W-1:0]  strafe_axis = '0;
    logic signed [AXIS_W-1:0]  forward_axis = '0;
    logic signed [AXIS_W-1:0]  turn_axis = '0;
    logic signed [AXIS_W-1:0]  throttle_axis = '0;
    logic                      hat_valid = 1'b0;
    logic [DIR_W-1:0]          hat_angle = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [AXIS_W-1:0]  front_right;
    logic signed [AXIS_W-1:0]  front_left;
    logic signed [AXIS_W-1:0]  back_right;
    logic signed [AXIS_W-1:0]  back_left;

    int mismatches;
    int outstanding;
    int send_idle_pct = 31;
    int recv_idle_pct = 69;
    int cycle_count = 0;
    bit stall_request = 1'b0;

    mecanum_wheel_mixer_top u_dut (.*);

    mecanum_mix_checker u_checker (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("mecanum_wheel_mixer_top test failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request so that
    // the output register and the sequencer both fill and the input stalls.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(input logic signed [AXIS_W-1:0] x, y, t, a,
                               input logic hv, input logic [DIR_W-1:0] ang);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        strafe_axis <= x;
        forward_axis <= y;
        turn_axis <= t;
        throttle_axis <= a;
        hat_valid <= hv;
        hat_angle <= ang;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    // Waits for every predicted result and then lets the bench settle; an item that
    // produces nothing never occupies the sequencer, so the block is then idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [AXIS_W-1:0] random_axis();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return $urandom_range(1) ? 16'sh8001 : ($urandom_range(1) ? 16'sh0 : 16'shFFFF);
            // Small values keep the sum of three such magnitudes at most 32769, one above full scale.
            2, 3, 4: return AXIS_W'($signed($urandom_range(21846)) - 10923);
            default: return AXIS_W'($urandom);
        endcase
    endfunction

    task automatic random_items(input int count, input int stall_at, input int pause_at);
        logic             hv;
        logic [DIR_W-1:0] ang;
        int               pick;
        for (int i = 0; i < count; i++)
        begin
            if (i == stall_at)
                stall_request = 1'b1;
            if (i == pause_at)
            begin
                in_valid <= 1'b0;
                while (outstanding != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                hv = 1'b1;
                case ($urandom_range(3))
                    0: ang = DIR_0;
                    1: ang = DIR_90;
                    2: ang = DIR_180;
                    default: ang = DIR_270;
                endcase
            end
            else if (pick < 85)
            begin
                hv = 1'b0;
                ang = DIR_W'($urandom_range(511));
            end
            else
            begin
                // Mostly stores a direction that suppresses results until the next press.
                hv = 1'b1;
                ang = DIR_W'($urandom_range(511));
            end
            send_sample(random_axis(), random_axis(), random_axis(), random_axis(), hv, ang);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed samples under the reset throttle setting.
        send_sample(0, 0, 0, 0, 1'b0, 9'd0);
        send_sample(32767, 0, 0, -32768, 1'b0, 9'd0);
        send_sample(-32768, 0, 0, -32768, 1'b0, 9'd0);
        send_sample(-32768, -32768, -32768, 32767, 1'b0, 9'd0);
        send_sample(32767, 32767, 32767, 0, 1'b1, DIR_0);
        send_sample(12000, -5000, 3000, -16384, 1'b1, DIR_90);
        send_sample(-20000, 7000, -9000, 8000, 1'b1, DIR_180);
        send_sample(5000, 30000, -1, 16384, 1'b1, DIR_270);
        send_sample(1000, 2000, 3000, 0, 1'b0, 9'd100);
        send_sample(1000, 2000, 3000, 0, 1'b1, 9'd45);
        send_sample(1, 1, 1, 1, 1'b0, 9'd0);
        send_sample(100, 200, 300, 400, 1'b1, 9'd359);
        send_sample(100, 200, 300, 400, 1'b1, 9'd360);
        send_sample(-1, -1, -1, -1, 1'b1, 9'd511);
        send_sample(0, -32768, 32767, -32768, 1'b1, DIR_90);
        send_sample(32767, -32768, -32768, 32767, 1'b1, DIR_270);
        send_sample(-32768, 32767, 0, -32768, 1'b1, DIR_180);
        send_sample(16384, 16384, 0, -32768, 1'b1, DIR_0);
        drain();

        write_reg(CFG_THR_MIN, 16'd0);
        write_reg(CFG_THR_RANGE, 16'd32768);
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h5A5A);
        cfg_write_en <= 1'b0;
        random_items(PHASE_ITEMS, -1, 200);
        drain();

        send_idle_pct = 69;
        recv_idle_pct = 31;
        write_reg(CFG_THR_MIN, 16'd32768);
        write_reg(CFG_THR_RANGE, 16'd0);
        cfg_write_en <= 1'b0;
        random_items(PHASE_ITEMS, -1, 150);
        drain();

        // Registers above full scale push the larger commands into saturation.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_THR_MIN, 16'hFFFF);
        write_reg(CFG_THR_RANGE, 16'hFFFF);
        cfg_write_en <= 1'b0;
        random_items(PHASE_ITEMS, 100, -1);
        drain();

        write_reg(CFG_THR_MIN, CFG_W'($urandom_range(32768)));
        write_reg(CFG_THR_RANGE, CFG_W'($urandom_range(32768)));
        cfg_write_en <= 1'b0;
        random_items(PHASE_ITEMS, -1, -1);
        drain();

        if (mismatches == 0 && outstanding == 0)
            $display("mecanum_wheel_mixer_top test passed");
        else
            $display("mecanum_wheel_mixer_top test failed");
        $finish;
    end

endmodule
